[hdl/qapm_pkg.sv]
`timescale 1ns / 1ps

package qapm_pkg;

   // Configuration register set, as held by the top level.
   typedef struct packed {
      logic        manual_mode;
      logic [14:0] auto_tilt_limit;
      logic [15:0] hover_thrust;
      logic [31:0] thrust_mix_gain;
      logic [31:0] tilt_mix_gain;
      logic [31:0] yaw_mix_gain;
      logic [15:0] tick_rate;
   } cfg_type;

   // Occupancy flags of the command queue.
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Pilot action codes.
   localparam logic [3:0] ACT_NONE       = 4'd0;
   localparam logic [3:0] ACT_UP         = 4'd1;
   localparam logic [3:0] ACT_DOWN       = 4'd2;
   localparam logic [3:0] ACT_PITCH_FWD  = 4'd3;
   localparam logic [3:0] ACT_PITCH_BACK = 4'd4;
   localparam logic [3:0] ACT_ROLL_LEFT  = 4'd5;
   localparam logic [3:0] ACT_ROLL_RIGHT = 4'd6;
   localparam logic [3:0] ACT_YAW_LEFT   = 4'd7;
   localparam logic [3:0] ACT_YAW_RIGHT  = 4'd8;

   // Register indexes.
   localparam logic [2:0] REG_MANUAL_MODE     = 3'd0;
   localparam logic [2:0] REG_AUTO_TILT_LIMIT = 3'd1;
   localparam logic [2:0] REG_HOVER_THRUST    = 3'd2;
   localparam logic [2:0] REG_THRUST_MIX_GAIN = 3'd3;
   localparam logic [2:0] REG_TILT_MIX_GAIN   = 3'd4;
   localparam logic [2:0] REG_YAW_MIX_GAIN    = 3'd5;
   localparam logic [2:0] REG_TICK_RATE       = 3'd6;

   // Gains in Q.16.
   localparam logic [16:0] KP_TILT = 17'd98304;
   localparam logic [16:0] KD_TILT = 17'd52429;
   localparam logic [16:0] KP_YAW  = 17'd65536;
   localparam logic [16:0] KD_YAW  = 17'd13107;

   // Thrust steps in Q8.8 newtons.
   localparam logic signed [17:0] BOOST_MANUAL = 18'sd3072;
   localparam logic signed [17:0] BOOST_AUTO   = 18'sd1024;

   localparam logic [27:0] MOMENT_MAX = 28'd134217727;

   // Angle constants scaled by 2^30.
   localparam longint unsigned PI_2P30         = 64'd3373259426;
   localparam longint unsigned INC_MANUAL_2P30 = 64'd21474836;
   localparam longint unsigned INC_AUTO_2P30   = 64'd53687091;

   // Datapath widths.
   localparam int THRUST_W = 18;
   localparam int MOM_W    = 28;
   localparam int MA_W     = 34;
   localparam int MB_W     = 33;
   localparam int ACC_W    = 64;
   localparam int XW       = 46;

   // Rounds a 2^30-scaled angle to 2^f scaling.
   function automatic int angle_const(input int f, input longint unsigned c30);
      return int'(((c30 >> (29 - f)) + 64'd1) >> 1);
   endfunction

endpackage

[hdl/qapm_front.sv]
`timescale 1ns / 1ps

module qapm_front #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int TARGET_WIDTH    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  qapm_pkg::cfg_type      cfg,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [55:0]            req_tdata,
   input  qapm_pkg::q_status_type q_status,
   output logic                   push,
   output logic [qapm_pkg::THRUST_W+3*TARGET_WIDTH+47:0] push_data
);
   import qapm_pkg::*;

   localparam int TW       = TARGET_WIDTH;
   localparam int YW       = TW + 1;
   localparam int PI_Q     = angle_const(ANGLE_FRAC_BITS, PI_2P30);
   localparam int INC_MAN  = angle_const(ANGLE_FRAC_BITS, INC_MANUAL_2P30);
   localparam int INC_AUTO = angle_const(ANGLE_FRAC_BITS, INC_AUTO_2P30);
   localparam int TILT_MAN = 1 << (ANGLE_FRAC_BITS - 1);

   logic signed [TW-1:0]       yaw_target_ff, yaw_target_in;
   logic                       accept;
   logic [3:0]                 action;
   logic signed [TW-1:0]       tilt, roll_t, pitch_t;
   logic signed [YW-1:0]       inc, yaw_step, yaw_wrap;
   logic signed [THRUST_W-1:0] boost, thrust;

   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && !q_status.full;
   assign push       = accept;
   assign action     = req_tdata[3:0];

   always_comb begin
      tilt     = cfg.manual_mode ? TW'(TILT_MAN) : TW'(cfg.auto_tilt_limit);
      inc      = cfg.manual_mode ? YW'(INC_MAN) : YW'(INC_AUTO);
      boost    = cfg.manual_mode ? BOOST_MANUAL : BOOST_AUTO;
      thrust   = $signed({2'b00, cfg.hover_thrust});
      roll_t   = '0;
      pitch_t  = '0;
      yaw_step = YW'(yaw_target_ff);
      unique case (action)
         ACT_UP:         thrust   = thrust + boost;
         ACT_DOWN:       thrust   = thrust - boost;
         ACT_PITCH_FWD:  pitch_t  = tilt;
         ACT_PITCH_BACK: pitch_t  = -tilt;
         ACT_ROLL_LEFT:  roll_t   = -tilt;
         ACT_ROLL_RIGHT: roll_t   = tilt;
         ACT_YAW_LEFT:   yaw_step = yaw_step - inc;
         ACT_YAW_RIGHT:  yaw_step = yaw_step + inc;
         default:        ;
      endcase
      // Keep the yaw target inside [-pi, pi).
      priority if (yaw_step >= YW'(PI_Q)) begin
         yaw_wrap = yaw_step - YW'(2 * PI_Q);
      end else if (yaw_step < -YW'(PI_Q)) begin
         yaw_wrap = yaw_step + YW'(2 * PI_Q);
      end else begin
         yaw_wrap = yaw_step;
      end
      yaw_target_in = accept ? yaw_wrap[TW-1:0] : yaw_target_ff;
   end

   assign push_data = {req_tdata[51:4], yaw_wrap[TW-1:0], pitch_t, roll_t, thrust};

   always_ff @(posedge clock) begin
      if (reset) begin
         yaw_target_ff <= '0;
      end else begin
         yaw_target_ff <= yaw_target_in;
      end
   end

endmodule

[hdl/qapm_queue.sv]
`timescale 1ns / 1ps

module qapm_queue #(
   parameter int WIDTH = 114
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       push_data,
   input  logic                   pop,
   output logic [WIDTH-1:0]       pop_data,
   output qapm_pkg::q_status_type status
);
   import qapm_pkg::*;

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hdl/qapm_back.sv]
`timescale 1ns / 1ps

module qapm_back #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int SPEED_WIDTH     = 16,
   parameter int TARGET_WIDTH    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  qapm_pkg::cfg_type      cfg,
   input  qapm_pkg::q_status_type q_status,
   input  logic [qapm_pkg::THRUST_W+3*TARGET_WIDTH+47:0] pop_data,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [63:0]            rsp_tdata
);
   import qapm_pkg::*;

   localparam int TW       = TARGET_WIDTH;
   localparam int EW       = TW + 1;
   localparam int RSHIFT   = ANGLE_FRAC_BITS + 8;
   localparam int SQ_STEPS = XW / 2;
   localparam logic [32:0] SMAX = (33'd1 << SPEED_WIDTH) - 33'd1;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_DMUL = 4'd1;
   localparam logic [3:0] ST_KD   = 4'd2;
   localparam logic [3:0] ST_KP   = 4'd3;
   localparam logic [3:0] ST_ACC  = 4'd4;
   localparam logic [3:0] ST_RND  = 4'd5;
   localparam logic [3:0] ST_MB   = 4'd6;
   localparam logic [3:0] ST_MP   = 4'd7;
   localparam logic [3:0] ST_MR   = 4'd8;
   localparam logic [3:0] ST_MY   = 4'd9;
   localparam logic [3:0] ST_MSUM = 4'd10;
   localparam logic [3:0] ST_WSEL = 4'd11;
   localparam logic [3:0] ST_SQRT = 4'd12;
   localparam logic [3:0] ST_OUT  = 4'd13;

   // Unpacked queue head.
   logic signed [THRUST_W-1:0] thrust;
   logic signed [TW-1:0]       target [3];
   logic signed [15:0]         meas [3];

   logic [3:0]              state_ff, state_in;
   logic [1:0]              axis_ff, axis_in, motor_ff, motor_in;
   logic [4:0]              step_ff, step_in;
   logic signed [15:0]      last_ff [3];
   logic signed [15:0]      last_in [3];
   logic signed [MOM_W-1:0] moment_ff [3];
   logic signed [MOM_W-1:0] moment_in [3];
   logic signed [ACC_W-1:0] product_ff, product_in, acc_ff, acc_in;
   logic signed [ACC_W-1:0] base_ff, base_in, pt_ff, pt_in, rt_ff, rt_in, yt_ff, yt_in;
   logic [XW-1:0]           x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic [15:0]             speed_ff [4];
   logic [15:0]             speed_in [4];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [63:0]             rsp_data_ff, rsp_data_in;

   logic signed [MA_W-1:0]      mul_a;
   logic signed [MB_W-1:0]      mul_b;
   logic signed [MA_W+MB_W-1:0] mul_p;
   logic signed [16:0]          delta;
   logic signed [EW-1:0]        err;
   logic [16:0]                 kp_sel, kd_sel;
   logic                        acc_neg;
   logic [ACC_W-1:0]            acc_mag, rnd;
   logic [MOM_W-1:0]            rnd_sat;
   logic signed [MOM_W-1:0]     moment_rnd;
   logic signed [ACC_W-1:0]     w;
   logic [XW-1:0]               trial, res_step;
   logic                        out_free;

   assign thrust    = pop_data[THRUST_W-1:0];
   assign target[0] = pop_data[THRUST_W +: TW];
   assign target[1] = pop_data[THRUST_W+TW +: TW];
   assign target[2] = pop_data[THRUST_W+2*TW +: TW];
   assign meas[0]   = pop_data[THRUST_W+3*TW +: 16];
   assign meas[1]   = pop_data[THRUST_W+3*TW+16 +: 16];
   assign meas[2]   = pop_data[THRUST_W+3*TW+32 +: 16];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Axis-dependent operands of the PD loop.
   always_comb begin
      delta  = 17'(meas[axis_ff]) - 17'(last_ff[axis_ff]);
      err    = EW'(target[axis_ff]) - EW'(meas[axis_ff]);
      kp_sel = (axis_ff == 2'd2) ? KP_YAW : KP_TILT;
      kd_sel = (axis_ff == 2'd2) ? KD_YAW : KD_TILT;
   end

   // Shared multiplier, registered on its output.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_DMUL: begin
            mul_a = MA_W'(delta);
            mul_b = $signed({17'd0, cfg.tick_rate});
         end
         ST_KD: begin
            mul_a = product_ff[MA_W-1:0];
            mul_b = $signed({16'd0, kd_sel});
         end
         ST_KP: begin
            mul_a = MA_W'(err);
            mul_b = $signed({16'd0, kp_sel});
         end
         ST_MB: begin
            mul_a = MA_W'(thrust);
            mul_b = $signed({1'b0, cfg.thrust_mix_gain});
         end
         ST_MP: begin
            mul_a = MA_W'(moment_ff[1]);
            mul_b = $signed({1'b0, cfg.tilt_mix_gain});
         end
         ST_MR: begin
            mul_a = MA_W'(moment_ff[0]);
            mul_b = $signed({1'b0, cfg.tilt_mix_gain});
         end
         ST_MY: begin
            mul_a = MA_W'(moment_ff[2]);
            mul_b = $signed({1'b0, cfg.yaw_mix_gain});
         end
         default: ;
      endcase
      mul_p      = mul_a * mul_b;
      product_in = mul_p[ACC_W-1:0];
   end

   // Round half away from zero to Q.8, then saturate.
   always_comb begin
      acc_neg    = acc_ff[ACC_W-1];
      acc_mag    = acc_neg ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      rnd        = (acc_mag + (64'd1 << (RSHIFT - 1))) >> RSHIFT;
      rnd_sat    = (rnd > ACC_W'(MOMENT_MAX)) ? MOMENT_MAX : rnd[MOM_W-1:0];
      moment_rnd = acc_neg ? -$signed(rnd_sat) : $signed(rnd_sat);
   end

   // Plus mixer, one motor at a time.
   always_comb begin
      unique case (motor_ff)
         2'd0:    w = base_ff + pt_ff - yt_ff;
         2'd1:    w = base_ff - rt_ff + yt_ff;
         2'd2:    w = base_ff - pt_ff - yt_ff;
         default: w = base_ff + rt_ff + yt_ff;
      endcase
   end

   always_comb begin
      trial    = res_ff + bit_ff;
      res_step = (x_ff >= trial) ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      motor_in     = motor_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      moment_in    = moment_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      pt_in        = pt_ff;
      rt_in        = rt_ff;
      yt_in        = yt_ff;
      x_in         = x_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      speed_in     = speed_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               axis_in  = 2'd0;
               state_in = ST_DMUL;
            end
         end
         ST_DMUL: begin
            last_in[axis_ff] = meas[axis_ff];
            state_in         = ST_KD;
         end
         ST_KD: state_in = ST_KP;
         ST_KP: begin
            acc_in   = -product_ff;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_ff + product_ff;
            state_in = ST_RND;
         end
         ST_RND: begin
            moment_in[axis_ff] = moment_rnd;
            if (axis_ff == 2'd2) begin
               state_in = ST_MB;
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = ST_DMUL;
            end
         end
         ST_MB: state_in = ST_MP;
         ST_MP: begin
            base_in  = product_ff;
            state_in = ST_MR;
         end
         ST_MR: begin
            pt_in    = product_ff;
            state_in = ST_MY;
         end
         ST_MY: begin
            rt_in    = product_ff;
            state_in = ST_MSUM;
         end
         ST_MSUM: begin
            yt_in    = product_ff;
            motor_in = 2'd0;
            state_in = ST_WSEL;
         end
         ST_WSEL: begin
            // A speed-squared value at or below zero gives a stopped motor.
            x_in     = (w > 0) ? w[XW+15:16] : '0;
            res_in   = '0;
            bit_in   = XW'(1) << (XW - 2);
            step_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (x_ff >= trial) begin
               x_in = x_ff - trial;
            end
            res_in  = res_step;
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(SQ_STEPS - 1)) begin
               speed_in[motor_ff] = (res_step > XW'(SMAX)) ? SMAX[15:0] : res_step[15:0];
               if (motor_ff == 2'd3) begin
                  state_in = ST_OUT;
               end else begin
                  motor_in = motor_ff + 2'd1;
                  state_in = ST_WSEL;
               end
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_data_in  = {speed_ff[3], speed_ff[2], speed_ff[1], speed_ff[0]};
               rsp_valid_in = 1'b1;
               pop          = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      product_ff  <= product_in;
      acc_ff      <= acc_in;
      moment_ff   <= moment_in;
      base_ff     <= base_in;
      pt_ff       <= pt_in;
      rt_ff       <= rt_in;
      yt_ff       <= yt_in;
      x_ff        <= x_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      speed_ff    <= speed_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= 2'd0;
         motor_ff     <= 2'd0;
         step_ff      <= 5'd0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         motor_ff     <= motor_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

endmodule

[hdl/quad_attitude_pid_mixer_unit.sv]
// The back end takes one queued transaction at a time through an idle check, three PD
// loops on the shared multiplier, the mixer steps, four square roots and an output step;
// the front end accepts new transactions into the queue meanwhile. A held result stalls
// the back end; the two-entry queue then fills up.
// Reset is synchronous and active high: it restores the registers to their defaults and
// clears the yaw target, the stored measurements, the queue and the result valid flag.
`timescale 1ns / 1ps

module quad_attitude_pid_mixer_unit #(
   parameter int ANGLE_FRAC_BITS = 13,
   parameter int SPEED_WIDTH     = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Command channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // action[3:0], roll_meas[19:4], pitch_meas[35:20],
                                    // yaw_meas[51:36], zero fill above
   // Motor speed channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // front_speed[15:0], left_speed[31:16],
                                    // rear_speed[47:32], right_speed[63:48]
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import qapm_pkg::*;

   // The target words must hold the yaw target in [-pi, pi) and a negated 15-bit tilt.
   localparam int TARGET_WIDTH = (ANGLE_FRAC_BITS + 3 > 16) ? ANGLE_FRAC_BITS + 3 : 16;
   localparam int ENTRY_W      = THRUST_W + 3 * TARGET_WIDTH + 48;

   cfg_type          cfg_ff, cfg_in;
   logic             csr_write;
   logic [2:0]       csr_index;
   q_status_type     q_status;
   logic             q_push, q_pop;
   logic [ENTRY_W-1:0] q_push_data, q_pop_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   // Register writes are taken at the clock edge that ends the access cycle; an index past the list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MANUAL_MODE:     cfg_in.manual_mode     = csr_pwdata[0];
            REG_AUTO_TILT_LIMIT: cfg_in.auto_tilt_limit = csr_pwdata[14:0];
            REG_HOVER_THRUST:    cfg_in.hover_thrust    = csr_pwdata[15:0];
            REG_THRUST_MIX_GAIN: cfg_in.thrust_mix_gain = csr_pwdata;
            REG_TILT_MIX_GAIN:   cfg_in.tilt_mix_gain   = csr_pwdata;
            REG_YAW_MIX_GAIN:    cfg_in.yaw_mix_gain    = csr_pwdata;
            REG_TICK_RATE:       cfg_in.tick_rate       = csr_pwdata[15:0];
            default:             ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MANUAL_MODE:     csr_prdata = {31'd0, cfg_ff.manual_mode};
         REG_AUTO_TILT_LIMIT: csr_prdata = {17'd0, cfg_ff.auto_tilt_limit};
         REG_HOVER_THRUST:    csr_prdata = {16'd0, cfg_ff.hover_thrust};
         REG_THRUST_MIX_GAIN: csr_prdata = cfg_ff.thrust_mix_gain;
         REG_TILT_MIX_GAIN:   csr_prdata = cfg_ff.tilt_mix_gain;
         REG_YAW_MIX_GAIN:    csr_prdata = cfg_ff.yaw_mix_gain;
         REG_TICK_RATE:       csr_prdata = {16'd0, cfg_ff.tick_rate};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.manual_mode     <= 1'b0;
         cfg_ff.auto_tilt_limit <= 15'd2458;
         cfg_ff.hover_thrust    <= 16'd2511;
         cfg_ff.thrust_mix_gain <= 32'd0;
         cfg_ff.tilt_mix_gain   <= 32'd0;
         cfg_ff.yaw_mix_gain    <= 32'd0;
         cfg_ff.tick_rate       <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front end decodes the action and updates the yaw target as each
   // transaction is taken, so the command queue holds finished targets.
   qapm_front #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .TARGET_WIDTH   (TARGET_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .q_status  (q_status),
      .push      (q_push),
      .push_data (q_push_data)
   );

   qapm_queue #(
      .WIDTH(ENTRY_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .status   (q_status)
   );

   // The back end runs the PD loops and the mixer on one shared multiplier,
   // then takes the four square roots one bit per cycle.
   qapm_back #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
      .SPEED_WIDTH    (SPEED_WIDTH),
      .TARGET_WIDTH   (TARGET_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .pop_data  (q_pop_data),
      .pop       (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

`ifndef SYNTH
   // The queue can never report full and empty together.
   a_queue_flags: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("command queue full and empty at once");

   // The back end only retires a command that is present.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("command popped from an empty queue");

   // No result is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule
